// ===== hdl/circle_circle_intersection_core_macros.svh =====
// Assertion macros shared by the circle intersection RTL.
`ifndef CIRCLE_CIRCLE_INTERSECTION_CORE_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset.
`define CCIC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never occurs.
`define CCIC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CCIC_ASSERT(name, prop, msg)
`define CCIC_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== hdl/ccic_pkg.sv =====
// Types and constants for the circle intersection core.
`timescale 1ns / 1ps
package ccic_pkg;

  localparam int unsigned CoordW    = 32;   // Q16.16 coordinate
  localparam int unsigned RadW      = 31;   // magnitude of a valid radius
  localparam int unsigned MagW      = 33;   // |center difference|
  localparam int unsigned SqW       = 64;   // squared distances
  localparam int unsigned RsqW      = 62;   // squared radii
  localparam int unsigned NmW       = 65;   // |N| of the chord equation
  localparam int unsigned RadicandW = 128;  // K
  localparam int unsigned RootW     = RadicandW / 2;
  localparam int unsigned NumW      = 100;  // signed chord numerators
  localparam int unsigned QuotW     = 40;   // offset clamps at 2^QuotW
  localparam int unsigned PlaceW    = 42;   // center plus offset before saturation
  localparam int unsigned NumPts    = 4;

  // point coordinate lanes
  localparam int unsigned LaneFirstX  = 0;
  localparam int unsigned LaneFirstY  = 1;
  localparam int unsigned LaneSecondX = 2;
  localparam int unsigned LaneSecondY = 3;

  localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] first_center_x;
    logic signed [CoordW-1:0] first_center_y;
    logic signed [CoordW-1:0] first_radius;
    logic signed [CoordW-1:0] second_center_x;
    logic signed [CoordW-1:0] second_center_y;
    logic signed [CoordW-1:0] second_radius;
  } ccic_item_t;

  typedef struct packed {
    logic                     found;
    logic signed [CoordW-1:0] first_point_x;
    logic signed [CoordW-1:0] first_point_y;
    logic signed [CoordW-1:0] second_point_x;
    logic signed [CoordW-1:0] second_point_y;
  } ccic_result_t;

  // front side-band through the squaring multipliers
  typedef struct packed {
    logic                     rej;
    logic signed [CoordW-1:0] cx1;
    logic signed [CoordW-1:0] cy1;
    logic                     a_neg;
    logic                     b_neg;
    logic [MagW-1:0]          am;
    logic [MagW-1:0]          bm;
  } ccic_ftag_t;

  // classified job held in the queue
  typedef struct packed {
    logic                     rej;
    logic signed [CoordW-1:0] cx1;
    logic signed [CoordW-1:0] cy1;
    logic                     a_neg;
    logic                     b_neg;
    logic [MagW-1:0]          am;
    logic [MagW-1:0]          bm;
    logic [SqW-1:0]           s;
    logic [SqW-1:0]           sq;
    logic [RsqW-1:0]          dq;
    logic [RsqW-1:0]          r1sq;
    logic [RsqW-1:0]          r2sq;
  } ccic_job_t;

  // back side-band through the K multiplier and square root
  typedef struct packed {
    logic                     rej;
    logic signed [CoordW-1:0] cx1;
    logic signed [CoordW-1:0] cy1;
    logic                     a_neg;
    logic                     b_neg;
    logic                     s_neg;
    logic                     n_neg;
    logic [MagW-1:0]          am;
    logic [MagW-1:0]          bm;
    logic [SqW-1:0]           s;
    logic [NmW-1:0]           nm;
  } ccic_btag_t;

  // side-band through the chord products
  typedef struct packed {
    logic                     rej;
    logic signed [CoordW-1:0] cx1;
    logic signed [CoordW-1:0] cy1;
    logic                     nx_neg;
    logic                     ny_neg;
    logic                     tx_neg;
    logic                     ty_neg;
    logic [SqW-1:0]           s;
  } ccic_ptag_t;

  // side-band through one divider lane
  typedef struct packed {
    logic                     rej;
    logic                     neg;
    logic signed [CoordW-1:0] c;
  } ccic_dtag_t;

endpackage

// ===== hdl/ccic_mul.sv =====
// Two-stage unsigned multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module ccic_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32,
  parameter int unsigned TW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [TW-1:0]    tag_i,
  output logic             valid_o,
  output logic [AW+BW-1:0] prod_o,
  output logic [TW-1:0]    tag_o
);
  localparam int unsigned ChunkW = 32;
  localparam int unsigned NA     = (AW + ChunkW - 1) / ChunkW;
  localparam int unsigned NB     = (BW + ChunkW - 1) / ChunkW;
  localparam int unsigned NP     = NA * NB;
  localparam int unsigned PW     = AW + BW;

  logic [NA*ChunkW-1:0] a_ext;
  logic [NB*ChunkW-1:0] b_ext;
  logic [2*ChunkW-1:0]  pp_q [NP];
  logic                 vld1_q;
  logic [TW-1:0]        tag1_q;
  logic [PW-1:0]        acc;
  logic                 vld2_q;
  logic [PW-1:0]        prod_q;
  logic [TW-1:0]        tag2_q;

  assign a_ext = (NA*ChunkW)'(a_i);
  assign b_ext = (NB*ChunkW)'(b_i);

  // partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= {{ChunkW{1'b0}}, a_ext[i*ChunkW +: ChunkW]} *
                        {{ChunkW{1'b0}}, b_ext[j*ChunkW +: ChunkW]};
      end
    end
    tag1_q <= tag_i;
  end

  // align and sum
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_q[i*NB+j]) << (ChunkW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= acc;
    tag2_q <= tag1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o = vld2_q;
  assign prod_o  = prod_q;
  assign tag_o   = tag2_q;
endmodule

// ===== hdl/ccic_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ccic_sqrt #(
  parameter int unsigned InW = 128,
  parameter int unsigned TW  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [InW-1:0]   rad_i,
  input  logic [TW-1:0]    tag_i,
  output logic             valid_o,
  output logic [InW/2-1:0] root_o,
  output logic [TW-1:0]    tag_o
);
  localparam int unsigned RtW  = InW / 2;
  localparam int unsigned RemW = InW + 1;

  logic            vld_q  [RtW];
  logic [RemW-1:0] rem_q  [RtW];
  logic [RtW-1:0]  root_q [RtW];
  logic [TW-1:0]   tag_q  [RtW];

  for (genvar k = 0; k < RtW; k++) begin : g_stage
    localparam int unsigned Bit = RtW - 1 - k;
    logic            src_vld;
    logic [RemW-1:0] src_rem;
    logic [RtW-1:0]  src_root;
    logic [TW-1:0]   src_tag;
    logic [RemW-1:0] trial;
    logic            take;

    if (k == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_rem  = RemW'(rad_i);
      assign src_root = '0;
      assign src_tag  = tag_i;
    end else begin : g_next
      assign src_vld  = vld_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_root = root_q[k-1];
      assign src_tag  = tag_q[k-1];
    end

    // (root + 2^Bit)^2 - root^2
    assign trial = (RemW'(src_root) << (Bit + 1)) + (RemW'(1) << (2 * Bit));
    assign take  = src_rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? src_rem - trial : src_rem;
      root_q[k] <= take ? (src_root | (RtW'(1) << Bit)) : src_root;
      tag_q[k]  <= src_tag;
    end
  end

  assign valid_o = vld_q[RtW-1];
  assign root_o  = root_q[RtW-1];
  assign tag_o   = tag_q[RtW-1];
endmodule

// ===== hdl/ccic_div.sv =====
// Pipelined restoring divider with a clamped quotient, one bit per stage.
`timescale 1ns / 1ps
module ccic_div #(
  parameter int unsigned NumW  = 100,
  parameter int unsigned DenW  = 65,
  parameter int unsigned QuotW = 40,
  parameter int unsigned TW    = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [QuotW:0]  quo_o,
  output logic [TW-1:0]   tag_o
);
  localparam int unsigned RW = ((NumW > DenW + QuotW) ? NumW : DenW + QuotW) + 1;

  logic             p_vld_q;
  logic [RW-1:0]    p_rem_q;
  logic [DenW-1:0]  p_den_q;
  logic             p_sat_q;
  logic [TW-1:0]    p_tag_q;

  logic             vld_q [QuotW];
  logic [RW-1:0]    rem_q [QuotW];
  logic [DenW-1:0]  den_q [QuotW];
  logic             sat_q [QuotW];
  logic [QuotW-1:0] quo_q [QuotW];
  logic [TW-1:0]    tag_q [QuotW];

  // quotient of 2^QuotW or more clamps; the bit stages then only see q < 2^QuotW
  always_ff @(posedge clk_i) begin
    p_rem_q <= RW'(num_i);
    p_den_q <= den_i;
    p_sat_q <= RW'(num_i) >= (RW'(den_i) << QuotW);
    p_tag_q <= tag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= valid_i;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned Bit = QuotW - 1 - k;
    logic             src_vld;
    logic [RW-1:0]    src_rem;
    logic [DenW-1:0]  src_den;
    logic             src_sat;
    logic [QuotW-1:0] src_quo;
    logic [TW-1:0]    src_tag;
    logic [RW-1:0]    trial;
    logic             take;

    if (k == 0) begin : g_first
      assign src_vld = p_vld_q;
      assign src_rem = p_rem_q;
      assign src_den = p_den_q;
      assign src_sat = p_sat_q;
      assign src_quo = '0;
      assign src_tag = p_tag_q;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src_rem = rem_q[k-1];
      assign src_den = den_q[k-1];
      assign src_sat = sat_q[k-1];
      assign src_quo = quo_q[k-1];
      assign src_tag = tag_q[k-1];
    end

    assign trial = RW'(src_den) << Bit;
    assign take  = src_rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? src_rem - trial : src_rem;
      den_q[k] <= src_den;
      sat_q[k] <= src_sat;
      quo_q[k] <= take ? (src_quo | (QuotW'(1) << Bit)) : src_quo;
      tag_q[k] <= src_tag;
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quo_o   = sat_q[QuotW-1] ? ((QuotW+1)'(1) << QuotW) : {1'b0, quo_q[QuotW-1]};
  assign tag_o   = tag_q[QuotW-1];
endmodule

// ===== hdl/ccic_front.sv =====
// Front end: take in circle pairs, square the distances and classify them.
`timescale 1ns / 1ps
module ccic_front #(
  parameter int unsigned CntW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ccic_pkg::ccic_item_t item_i,
  output logic                job_valid_o,
  output ccic_pkg::ccic_job_t  job_o,
  output logic [CntW-1:0]     inflight_o
);
  import ccic_pkg::*;

  logic [MagW-1:0]  a_diff, b_diff;
  logic [MagW-1:0]  a_mag, b_mag;
  logic             r1_bad, r2_bad;
  logic [CoordW-1:0] dr;
  ccic_ftag_t       s0_tag_d;

  logic             s0_valid_q;
  ccic_ftag_t       s0_tag_q;
  logic [CoordW-1:0] s0_sum_q;
  logic [RadW-1:0]  s0_dm_q, s0_r1_q, s0_r2_q;

  logic             m_valid;
  ccic_ftag_t       m_tag;
  logic [2*MagW-1:0] aa_p, bb_p;
  logic [SqW-1:0]   ss_p;
  logic [RsqW-1:0]  dd_p, r1_p, r2_p;

  logic [SqW+2:0]   s_sum;
  logic             far, inner;
  ccic_job_t        job_d, job_q;
  logic             job_valid_q;
  logic [CntW-1:0]  cnt_d, cnt_q;

  // differences (second minus first), sign kept apart from magnitude
  always_comb begin
    a_diff = MagW'({item_i.second_center_x[CoordW-1], item_i.second_center_x}) -
             MagW'({item_i.first_center_x[CoordW-1], item_i.first_center_x});
    b_diff = MagW'({item_i.second_center_y[CoordW-1], item_i.second_center_y}) -
             MagW'({item_i.first_center_y[CoordW-1], item_i.first_center_y});
    a_mag  = a_diff[MagW-1] ? MagW'(-a_diff[MagW-1:0]) : a_diff[MagW-1:0];
    b_mag  = b_diff[MagW-1] ? MagW'(-b_diff[MagW-1:0]) : b_diff[MagW-1:0];
    r1_bad = item_i.first_radius[CoordW-1] || (item_i.first_radius == '0);
    r2_bad = item_i.second_radius[CoordW-1] || (item_i.second_radius == '0);
    dr     = item_i.first_radius - item_i.second_radius;

    s0_tag_d.rej   = r1_bad || r2_bad || (a_diff[MagW-1:0] == '0 && b_diff[MagW-1:0] == '0);
    s0_tag_d.cx1   = item_i.first_center_x;
    s0_tag_d.cy1   = item_i.first_center_y;
    s0_tag_d.a_neg = a_diff[MagW-1];
    s0_tag_d.b_neg = b_diff[MagW-1];
    s0_tag_d.am    = a_mag;
    s0_tag_d.bm    = b_mag;
  end

  always_ff @(posedge clk_i) begin
    s0_tag_q <= s0_tag_d;
    s0_sum_q <= item_i.first_radius + item_i.second_radius;
    s0_dm_q  <= dr[CoordW-1] ? RadW'(-dr) : dr[RadW-1:0];
    s0_r1_q  <= item_i.first_radius[RadW-1:0];
    s0_r2_q  <= item_i.second_radius[RadW-1:0];
  end

  ccic_mul #(.AW(MagW), .BW(MagW), .TW($bits(ccic_ftag_t))) u_mul_aa (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_tag_q.am), .b_i(s0_tag_q.am),
    .tag_i(s0_tag_q), .valid_o(m_valid), .prod_o(aa_p), .tag_o(m_tag)
  );
  ccic_mul #(.AW(MagW), .BW(MagW), .TW(1)) u_mul_bb (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_tag_q.bm), .b_i(s0_tag_q.bm),
    .tag_i(1'b0), .valid_o(), .prod_o(bb_p), .tag_o()
  );
  ccic_mul #(.AW(CoordW), .BW(CoordW), .TW(1)) u_mul_ss (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_sum_q), .b_i(s0_sum_q),
    .tag_i(1'b0), .valid_o(), .prod_o(ss_p), .tag_o()
  );
  ccic_mul #(.AW(RadW), .BW(RadW), .TW(1)) u_mul_dd (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_dm_q), .b_i(s0_dm_q),
    .tag_i(1'b0), .valid_o(), .prod_o(dd_p), .tag_o()
  );
  ccic_mul #(.AW(RadW), .BW(RadW), .TW(1)) u_mul_r1 (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_r1_q), .b_i(s0_r1_q),
    .tag_i(1'b0), .valid_o(), .prod_o(r1_p), .tag_o()
  );
  ccic_mul #(.AW(RadW), .BW(RadW), .TW(1)) u_mul_r2 (
    .clk_i, .rst_ni, .valid_i(s0_valid_q), .a_i(s0_r2_q), .b_i(s0_r2_q),
    .tag_i(1'b0), .valid_o(), .prod_o(r2_p), .tag_o()
  );

  // classify: too far (including a distance beyond 64 bits) or nested
  always_comb begin
    s_sum = (SqW+3)'(aa_p) + (SqW+3)'(bb_p);
    far   = (s_sum[SqW+2:SqW] != '0) || (s_sum[SqW-1:0] > ss_p);
    inner = SqW'(dd_p) > s_sum[SqW-1:0];

    job_d.rej   = m_tag.rej || far || inner;
    job_d.cx1   = m_tag.cx1;
    job_d.cy1   = m_tag.cy1;
    job_d.a_neg = m_tag.a_neg;
    job_d.b_neg = m_tag.b_neg;
    job_d.am    = m_tag.am;
    job_d.bm    = m_tag.bm;
    job_d.s     = s_sum[SqW-1:0];
    job_d.sq    = ss_p;
    job_d.dq    = dd_p;
    job_d.r1sq  = r1_p;
    job_d.r2sq  = r2_p;
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign cnt_d = cnt_q + CntW'(accept_i) - CntW'(job_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      s0_valid_q  <= accept_i;
      job_valid_q <= m_valid;
      cnt_q       <= cnt_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;
  assign inflight_o  = cnt_q;
endmodule

// ===== hdl/ccic_queue.sv =====
// Job queue between the front end and the solver.
`timescale 1ns / 1ps
`include "circle_circle_intersection_core_macros.svh"
module ccic_queue #(
  parameter int unsigned Depth = 8,
  parameter int unsigned CntW  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ccic_pkg::ccic_job_t push_data_i,
  input  logic               pop_i,
  output ccic_pkg::ccic_job_t pop_data_o,
  output logic               empty_o,
  output logic [CntW-1:0]    count_o
);
  import ccic_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);

  ccic_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            full;

  assign full    = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers wrap by width: Depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign count_o    = cnt_q;

  `CCIC_ASSERT_NEVER(a_push_full, push_i && full && !pop_i, "job pushed into a full queue")
  `CCIC_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "job popped from an empty queue")
  `CCIC_ASSERT(a_count_step, push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1),
               "queue count lost a push")
endmodule

// ===== hdl/ccic_back.sv =====
// Solver: chord equation, square root, four divides and saturation.
`timescale 1ns / 1ps
module ccic_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  ccic_pkg::ccic_job_t    job_i,
  output logic                  result_valid_o,
  output ccic_pkg::ccic_result_t result_o
);
  import ccic_pkg::*;

  // stage B0: chord terms
  logic [NmW-1:0]  pa, pb;
  ccic_btag_t      b0_tag_d, b0_tag_q;
  logic            b0_valid_q;
  logic [SqW-1:0]  b0_u_q, b0_v_q;

  // K and its root
  logic            k_valid;
  logic [RadicandW-1:0] k_p;
  ccic_btag_t      k_tag;
  logic            r_valid;
  logic [RootW-1:0] root;
  ccic_btag_t      r_tag;

  // chord products
  ccic_ptag_t      p_tag_d, p_tag;
  logic            p_valid;
  logic [NmW+MagW-1:0]   nx_p, ny_p;
  logic [MagW+RootW-1:0] tx_p, ty_p;

  // stage B1: signed numerators
  logic [NumW-1:0] nxv, nyv, txv, tyv;
  logic [NumW-1:0] b1_sum_d [NumPts];
  logic [NumW-1:0] b1_sum_q [NumPts];
  ccic_ptag_t      b1_tag_q;
  logic            b1_valid_q;

  // stage B2: magnitude plus rounding term
  logic [NumW-1:0] b2_num_d [NumPts];
  logic [NumW-1:0] b2_num_q [NumPts];
  logic            b2_neg_q [NumPts];
  ccic_ptag_t      b2_tag_q;
  logic            b2_valid_q;

  // divider lanes
  logic            div_valid [NumPts];
  logic [QuotW:0]  div_quo   [NumPts];
  ccic_dtag_t      div_tag   [NumPts];
  logic [CoordW-1:0] pt      [NumPts];

  ccic_result_t    result_d, result_q;
  logic            result_valid_q;

  always_comb begin
    pa = NmW'(job_i.s) + NmW'(job_i.r1sq);
    pb = NmW'(job_i.r2sq);
    b0_tag_d.rej   = job_i.rej;
    b0_tag_d.cx1   = job_i.cx1;
    b0_tag_d.cy1   = job_i.cy1;
    b0_tag_d.a_neg = job_i.a_neg;
    b0_tag_d.b_neg = job_i.b_neg;
    // orientation follows a, or the opposite of b when the centers share x
    b0_tag_d.s_neg = (job_i.am != '0) ? job_i.a_neg : (!job_i.b_neg && job_i.bm != '0);
    b0_tag_d.n_neg = pa < pb;
    b0_tag_d.am    = job_i.am;
    b0_tag_d.bm    = job_i.bm;
    b0_tag_d.s     = job_i.s;
    b0_tag_d.nm    = (pa < pb) ? pb - pa : pa - pb;
  end

  always_ff @(posedge clk_i) begin
    b0_tag_q <= b0_tag_d;
    b0_u_q   <= job_i.sq - job_i.s;
    b0_v_q   <= job_i.s - SqW'(job_i.dq);
  end

  ccic_mul #(.AW(SqW), .BW(SqW), .TW($bits(ccic_btag_t))) u_mul_k (
    .clk_i, .rst_ni, .valid_i(b0_valid_q), .a_i(b0_u_q), .b_i(b0_v_q),
    .tag_i(b0_tag_q), .valid_o(k_valid), .prod_o(k_p), .tag_o(k_tag)
  );

  ccic_sqrt #(.InW(RadicandW), .TW($bits(ccic_btag_t))) u_sqrt (
    .clk_i, .rst_ni, .valid_i(k_valid), .rad_i(k_p), .tag_i(k_tag),
    .valid_o(r_valid), .root_o(root), .tag_o(r_tag)
  );

  always_comb begin
    p_tag_d.rej    = r_tag.rej;
    p_tag_d.cx1    = r_tag.cx1;
    p_tag_d.cy1    = r_tag.cy1;
    p_tag_d.nx_neg = r_tag.n_neg ^ r_tag.a_neg;
    p_tag_d.ny_neg = r_tag.n_neg ^ r_tag.b_neg;
    p_tag_d.tx_neg = r_tag.s_neg ^ r_tag.b_neg;
    p_tag_d.ty_neg = r_tag.s_neg ^ r_tag.a_neg;
    p_tag_d.s      = r_tag.s;
  end

  ccic_mul #(.AW(NmW), .BW(MagW), .TW($bits(ccic_ptag_t))) u_mul_nx (
    .clk_i, .rst_ni, .valid_i(r_valid), .a_i(r_tag.nm), .b_i(r_tag.am),
    .tag_i(p_tag_d), .valid_o(p_valid), .prod_o(nx_p), .tag_o(p_tag)
  );
  ccic_mul #(.AW(NmW), .BW(MagW), .TW(1)) u_mul_ny (
    .clk_i, .rst_ni, .valid_i(r_valid), .a_i(r_tag.nm), .b_i(r_tag.bm),
    .tag_i(1'b0), .valid_o(), .prod_o(ny_p), .tag_o()
  );
  ccic_mul #(.AW(MagW), .BW(RootW), .TW(1)) u_mul_tx (
    .clk_i, .rst_ni, .valid_i(r_valid), .a_i(r_tag.bm), .b_i(root),
    .tag_i(1'b0), .valid_o(), .prod_o(tx_p), .tag_o()
  );
  ccic_mul #(.AW(MagW), .BW(RootW), .TW(1)) u_mul_ty (
    .clk_i, .rst_ni, .valid_i(r_valid), .a_i(r_tag.am), .b_i(root),
    .tag_i(1'b0), .valid_o(), .prod_o(ty_p), .tag_o()
  );

  always_comb begin
    nxv = p_tag.nx_neg ? NumW'(-NumW'(nx_p)) : NumW'(nx_p);
    nyv = p_tag.ny_neg ? NumW'(-NumW'(ny_p)) : NumW'(ny_p);
    txv = p_tag.tx_neg ? NumW'(-NumW'(tx_p)) : NumW'(tx_p);
    tyv = p_tag.ty_neg ? NumW'(-NumW'(ty_p)) : NumW'(ty_p);
    b1_sum_d[LaneFirstX]  = nxv - txv;
    b1_sum_d[LaneFirstY]  = nyv + tyv;
    b1_sum_d[LaneSecondX] = nxv + txv;
    b1_sum_d[LaneSecondY] = nyv - tyv;
  end

  always_ff @(posedge clk_i) begin
    b1_sum_q <= b1_sum_d;
    b1_tag_q <= p_tag;
  end

  // round half away from zero: (|num| + S) / (2S)
  always_comb begin
    for (int g = 0; g < NumPts; g++) begin
      b2_num_d[g] = (b1_sum_q[g][NumW-1] ? NumW'(-b1_sum_q[g]) : b1_sum_q[g]) +
                    NumW'(b1_tag_q.s);
    end
  end

  always_ff @(posedge clk_i) begin
    b2_num_q <= b2_num_d;
    for (int g = 0; g < NumPts; g++) begin
      b2_neg_q[g] <= b1_sum_q[g][NumW-1];
    end
    b2_tag_q <= b1_tag_q;
  end

  for (genvar g = 0; g < NumPts; g++) begin : g_lane
    ccic_dtag_t       dtag;
    logic [PlaceW-1:0] c_ext, o_ext, v;

    assign dtag.rej = b2_tag_q.rej;
    assign dtag.neg = b2_neg_q[g];
    assign dtag.c   = (g == LaneFirstX || g == LaneSecondX) ? b2_tag_q.cx1 : b2_tag_q.cy1;

    ccic_div #(.NumW(NumW), .DenW(SqW+1), .QuotW(QuotW), .TW($bits(ccic_dtag_t))) u_div (
      .clk_i, .rst_ni, .valid_i(b2_valid_q), .num_i(b2_num_q[g]),
      .den_i({b2_tag_q.s, 1'b0}), .tag_i(dtag),
      .valid_o(div_valid[g]), .quo_o(div_quo[g]), .tag_o(div_tag[g])
    );

    // center plus offset, saturated to the coordinate range
    assign c_ext = {{(PlaceW-CoordW){div_tag[g].c[CoordW-1]}}, div_tag[g].c};
    assign o_ext = PlaceW'(div_quo[g]);
    assign v     = div_tag[g].neg ? c_ext - o_ext : c_ext + o_ext;

    always_comb begin
      if (v[PlaceW-1:CoordW-1] == '0 || v[PlaceW-1:CoordW-1] == '1) begin
        pt[g] = v[CoordW-1:0];
      end else if (v[PlaceW-1]) begin
        pt[g] = CoordMin;
      end else begin
        pt[g] = CoordMax;
      end
    end
  end

  always_comb begin
    result_d.found          = !div_tag[LaneFirstX].rej;
    result_d.first_point_x  = div_tag[LaneFirstX].rej ? '0 : pt[LaneFirstX];
    result_d.first_point_y  = div_tag[LaneFirstX].rej ? '0 : pt[LaneFirstY];
    result_d.second_point_x = div_tag[LaneFirstX].rej ? '0 : pt[LaneSecondX];
    result_d.second_point_y = div_tag[LaneFirstX].rej ? '0 : pt[LaneSecondY];
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q     <= 1'b0;
      b1_valid_q     <= 1'b0;
      b2_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      b0_valid_q     <= job_valid_i;
      b1_valid_q     <= p_valid;
      b2_valid_q     <= b1_valid_q;
      result_valid_q <= div_valid[LaneFirstX];
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;
endmodule

// ===== hdl/circle_circle_intersection_core.sv =====
// Circle-circle intersection core, signed Q16.16, fully pipelined.
// Throughput: one transaction per cycle while busy is low; the 64-stage square root and 41-stage
// dividers set the latency, and every unit takes a new operand each cycle.
// Reset clears all valid bits, the queue pointers and the in-flight count; no data state.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "circle_circle_intersection_core_macros.svh"
module circle_circle_intersection_core #(
  parameter int unsigned QueueDepth = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ccic_pkg::ccic_item_t   item_i,
  output logic                  result_valid_o,
  output ccic_pkg::ccic_result_t result_o
);
  import ccic_pkg::*;

  // wide enough to hold QueueDepth itself
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            accept;
  logic            job_valid;
  ccic_job_t       job;
  logic [CntW-1:0] front_cnt;
  ccic_job_t       q_head;
  logic            q_empty;
  logic [CntW-1:0] q_cnt;
  logic            q_pop;

  // Hold off new transactions once the queue could not absorb everything
  // already in the front end. The solver drains the queue every cycle, so
  // with the default depth this never asserts.
  assign busy   = ((CntW+1)'(q_cnt) + (CntW+1)'(front_cnt)) >= (CntW+1)'(QueueDepth);
  assign accept = start && !busy;

  // Front: differences, squared distances, reject classes.
  ccic_front #(.CntW(CntW)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .item_i,
    .job_valid_o(job_valid), .job_o(job), .inflight_o(front_cnt)
  );

  // Decouple front and solver; pop whenever a job is waiting.
  assign q_pop = !q_empty;

  ccic_queue #(.Depth(QueueDepth), .CntW(CntW)) u_queue (
    .clk_i, .rst_ni, .push_i(job_valid), .push_data_i(job),
    .pop_i(q_pop), .pop_data_o(q_head), .empty_o(q_empty), .count_o(q_cnt)
  );

  // Solver: chord equation, root of K, rounded divides, saturation.
  ccic_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_pop), .job_i(q_head),
    .result_valid_o, .result_o
  );

  // A rejected transaction must come out with all points cleared.
  `CCIC_ASSERT(a_reject_zero, result_valid_o && !result_o.found |-> result_o.first_point_x == '0 && result_o.first_point_y == '0 && result_o.second_point_x == '0 && result_o.second_point_y == '0, "rejected result carries nonzero points")
endmodule
